[sv/assert_macros.svh]
// ----------------------------------------------------------------------------
// assert_macros.svh
// Assertion macros used by the checker file of this block.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion, disabled while reset is high.
`define SWS_ASSERT_CLK(lbl, clk, rst, prop, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Clocked assertion that also holds through reset.
`define SWS_ASSERT_RST(lbl, clk, prop, msg) \
   lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

[sv/sws_pkg.sv]
// ----------------------------------------------------------------------------
// sws_pkg
// Types and constants of the sliding window statistics block.
// ----------------------------------------------------------------------------
package sws_pkg;

   localparam int SAMPLE_BITS = 16;
   localparam int CMD_W       = 2;

   // commands carried in req_tuser
   localparam logic [CMD_W-1:0] CMD_PUSH      = 2'd0;
   localparam logic [CMD_W-1:0] CMD_CLR_WIN   = 2'd1;
   localparam logic [CMD_W-1:0] CMD_CLR_STATS = 2'd2;

   // result field widths
   localparam int CNT_OUT_W  = 9;
   localparam int SUM_OUT_W  = 24;
   localparam int MEAN_W     = 24;
   localparam int VAR_OUT_W  = 39;
   localparam int STD_W      = 24;
   localparam int TOT_W      = 32;
   localparam int RSP_DATA_W = 224;
   localparam int RSP_PAD_W  = RSP_DATA_W - (2 * CNT_OUT_W
                               + SUM_OUT_W + MEAN_W + 2 * SAMPLE_BITS + VAR_OUT_W
                               + STD_W + MEAN_W + TOT_W);

   localparam int MEAN_FRAC  = 8;
   localparam int VAR_SHIFT  = 16;

   // configuration port
   localparam int CSR_ADDR_W = 3;
   localparam int CSR_DATA_W = 32;
   localparam int WSIZE_W    = 9;
   localparam logic CSR_IDX_WINDOW_SIZE = 1'b0;
   localparam int WSIZE_RESET = 100;

   // shared divider and square root
   localparam int DVD_W  = 64;
   localparam int DVS_W  = 32;
   localparam int ROOT_W = 32;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_SCAN,
      ST_MUL,
      ST_MEAN_GO,
      ST_MEAN_WAIT,
      ST_ACC,
      ST_VAR_GO,
      ST_VAR_WAIT,
      ST_AVG_GO,
      ST_AVG_WAIT,
      ST_SQRT_GO,
      ST_SQRT_WAIT,
      ST_DONE
   } ctrl_state_type;

   typedef enum logic [1:0] {
      DSEL_MEAN,
      DSEL_VAR,
      DSEL_AVG
   } div_sel_type;

   typedef struct packed {
      logic        accept;
      logic        scan_step;
      logic        mul;
      logic        div_start;
      div_sel_type div_sel;
      logic        acc;
      logic        sqrt_start;
      logic        load_out;
   } ctrl_cmd_type;

   typedef struct packed {
      logic scan_done;
      logic div_done;
      logic sqrt_done;
      logic out_free;
   } ctrl_status_type;

endpackage

[sv/sliding_window_statistics.sv]
// ----------------------------------------------------------------------------
// sliding_window_statistics
// Sliding window mean, variance, min and max over signed 16-bit samples.
// ----------------------------------------------------------------------------
// Usage:
//   req channel: one transaction per command. req_tuser carries the command
//   (push, clear window, clear long-run statistics), req_tdata the sample.
//   rsp channel: one summary transaction per command.
//   csr port: window_size at byte address 0; writes clamp to 2..WINDOW_MAX.
// Timing:
//   One command at a time. Each command scans the window fill for
//   min/max/sum through the single sample memory read port, then runs
//   three divisions on the shared divider (mean, variance, average mean)
//   and a square root, with sequencing states between them.
//   rsp_tvalid rises in the same cycle as req_tready, when the next
//   command can first be accepted.
// Reset:
//   Synchronous. Window empty, long-run statistics zero, window_size 100
//   (or WINDOW_MAX if smaller). The sample memory is not cleared; only
//   entries inside the fill are ever read.
// Stall:
//   The summary sits in the output register until rsp_tready. The next
//   command is still accepted; its summary waits for the register to drain.
// ----------------------------------------------------------------------------
module sliding_window_statistics #(
   parameter int WINDOW_MAX = 256
) (
   input  logic                                clock,
   input  logic                                reset,
   // req_tdata: [15:0] sample
   input  logic                                req_tvalid,
   output logic                                req_tready,
   input  logic [sws_pkg::SAMPLE_BITS-1:0]     req_tdata,
   // req_tuser: [1:0] command
   input  logic [sws_pkg::CMD_W-1:0]           req_tuser,
   // rsp_tdata: [8:0] count, [32:9] window_sum, [56:33] mean_q8,
   //   [72:57] minimum, [88:73] maximum, [127:89] variance_q8,
   //   [151:128] stddev_q8, [175:152] average_mean_q8, [184:176] peak_count,
   //   [216:185] total_pushes, [223:217] zero
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   output logic [sws_pkg::RSP_DATA_W-1:0]      rsp_tdata,
   input  logic                                csr_psel,
   input  logic                                csr_penable,
   input  logic                                csr_pwrite,
   input  logic [sws_pkg::CSR_ADDR_W-1:0]      csr_paddr,
   input  logic [sws_pkg::CSR_DATA_W-1:0]      csr_pwdata,
   output logic [sws_pkg::CSR_DATA_W-1:0]      csr_prdata,
   output logic                                csr_pready
);
   sws_pkg::ctrl_cmd_type    cmd;
   sws_pkg::ctrl_status_type status;
   logic                     hit;
   logic                     cfg_wr;
   logic [$clog2(WINDOW_MAX+1)-1:0] wsize;

   // single register: word index is paddr above the byte offset
   assign hit        = csr_paddr[sws_pkg::CSR_ADDR_W-1:2] == sws_pkg::CSR_IDX_WINDOW_SIZE;
   assign csr_pready = 1'b1;
   assign cfg_wr     = csr_psel && csr_penable && csr_pwrite && hit;
   assign csr_prdata = hit ? sws_pkg::CSR_DATA_W'(wsize) : '0;

   sws_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .status     (status),
      .cmd        (cmd)
   );

   sws_dp #(
      .WINDOW_MAX (WINDOW_MAX)
   ) u_dp (
      .clock       (clock),
      .reset       (reset),
      .cmd         (cmd),
      .status      (status),
      .req_sample  (req_tdata),
      .req_command (req_tuser),
      .cfg_wr      (cfg_wr),
      .cfg_wdata   (csr_pwdata[sws_pkg::WSIZE_W-1:0]),
      .cfg_wsize   (wsize),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata)
   );
endmodule

[sv/sws_div.sv]
// ----------------------------------------------------------------------------
// sws_div
// Restoring unsigned divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module sws_div (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       start,
   input  logic [sws_pkg::DVD_W-1:0]  dividend,
   input  logic [sws_pkg::DVS_W-1:0]  divisor,
   output logic [sws_pkg::DVD_W-1:0]  quotient,
   output logic                       done
);
   localparam int DW = sws_pkg::DVD_W;
   localparam int VW = sws_pkg::DVS_W;
   localparam int CW = $clog2(DW);

   logic [DW-1:0] dvd_ff, dvd_in;
   logic [VW-1:0] dvs_ff;
   logic [VW-1:0] rem_ff, rem_in;
   logic [CW-1:0] cnt_ff, cnt_in;
   logic          busy_ff, busy_in;
   logic          done_ff, done_in;
   logic [VW:0]   rsh;
   logic          ge;

   always_comb begin
      rsh     = {rem_ff, dvd_ff[DW-1]};
      ge      = rsh >= {1'b0, dvs_ff};
      dvd_in  = dvd_ff;
      rem_in  = rem_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (start) begin
         dvd_in  = dividend;
         rem_in  = '0;
         cnt_in  = '0;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         rem_in = ge ? VW'(rsh - {1'b0, dvs_ff}) : rsh[VW-1:0];
         dvd_in = {dvd_ff[DW-2:0], ge};
         cnt_in = cnt_ff + 1'b1;
         if (cnt_ff == CW'(DW - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      dvd_ff <= dvd_in;
      rem_ff <= rem_in;
      if (start) dvs_ff <= divisor;
   end

   assign quotient = dvd_ff;
   assign done     = done_ff;
endmodule

[sv/sws_sqrt.sv]
// ----------------------------------------------------------------------------
// sws_sqrt
// Digit-by-digit floor square root, one root bit per cycle.
// ----------------------------------------------------------------------------
module sws_sqrt (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        start,
   input  logic [sws_pkg::DVD_W-1:0]   radicand,
   output logic [sws_pkg::ROOT_W-1:0]  root,
   output logic                        done
);
   localparam int XW = sws_pkg::DVD_W;

   logic [XW-1:0] x_ff, x_in;
   logic [XW-1:0] r_ff, r_in;
   logic [XW-1:0] bit_ff, bit_in;
   logic [XW-1:0] trial;
   logic          busy_ff, busy_in;
   logic          done_ff, done_in;

   always_comb begin
      trial   = r_ff + bit_ff;
      x_in    = x_ff;
      r_in    = r_ff;
      bit_in  = bit_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (start) begin
         x_in    = radicand;
         r_in    = '0;
         bit_in  = XW'(1) << (XW - 2);
         busy_in = 1'b1;
      end else if (busy_ff) begin
         if (x_ff >= trial) begin
            x_in = x_ff - trial;
            r_in = (r_ff >> 1) + bit_ff;
         end else begin
            r_in = r_ff >> 1;
         end
         bit_in = bit_ff >> 2;
         if (bit_ff[0]) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      x_ff   <= x_in;
      r_ff   <= r_in;
      bit_ff <= bit_in;
   end

   assign root = r_ff[sws_pkg::ROOT_W-1:0];
   assign done = done_ff;
endmodule

[sv/sws_ctrl.sv]
// ----------------------------------------------------------------------------
// sws_ctrl
// Sequencer: accept, window scan, multiplies, divisions, square root, output.
// ----------------------------------------------------------------------------
module sws_ctrl (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_tvalid,
   output logic                      req_tready,
   input  sws_pkg::ctrl_status_type  status,
   output sws_pkg::ctrl_cmd_type     cmd
);
   sws_pkg::ctrl_state_type state_ff, state_in;

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         sws_pkg::ST_IDLE:      if (req_tvalid) state_in = sws_pkg::ST_SCAN;
         sws_pkg::ST_SCAN:      if (status.scan_done) state_in = sws_pkg::ST_MUL;
         sws_pkg::ST_MUL:       state_in = sws_pkg::ST_MEAN_GO;
         sws_pkg::ST_MEAN_GO:   state_in = sws_pkg::ST_MEAN_WAIT;
         sws_pkg::ST_MEAN_WAIT: if (status.div_done) state_in = sws_pkg::ST_ACC;
         sws_pkg::ST_ACC:       state_in = sws_pkg::ST_VAR_GO;
         sws_pkg::ST_VAR_GO:    state_in = sws_pkg::ST_VAR_WAIT;
         sws_pkg::ST_VAR_WAIT:  if (status.div_done) state_in = sws_pkg::ST_AVG_GO;
         sws_pkg::ST_AVG_GO:    state_in = sws_pkg::ST_AVG_WAIT;
         sws_pkg::ST_AVG_WAIT:  if (status.div_done) state_in = sws_pkg::ST_SQRT_GO;
         sws_pkg::ST_SQRT_GO:   state_in = sws_pkg::ST_SQRT_WAIT;
         sws_pkg::ST_SQRT_WAIT: if (status.sqrt_done) state_in = sws_pkg::ST_DONE;
         sws_pkg::ST_DONE:      if (status.out_free) state_in = sws_pkg::ST_IDLE;
         default:               state_in = sws_pkg::ST_IDLE;
      endcase
   end

   always_comb begin
      cmd         = '0;
      cmd.div_sel = sws_pkg::DSEL_MEAN;
      req_tready  = 1'b0;
      unique case (state_ff)
         sws_pkg::ST_IDLE: begin
            // nothing is taken while reset is held
            req_tready = !reset;
            cmd.accept = req_tvalid && !reset;
         end
         sws_pkg::ST_SCAN:    cmd.scan_step = 1'b1;
         sws_pkg::ST_MUL:     cmd.mul = 1'b1;
         sws_pkg::ST_MEAN_GO: begin
            cmd.div_start = 1'b1;
            cmd.div_sel   = sws_pkg::DSEL_MEAN;
         end
         sws_pkg::ST_ACC:     cmd.acc = 1'b1;
         sws_pkg::ST_VAR_GO: begin
            cmd.div_start = 1'b1;
            cmd.div_sel   = sws_pkg::DSEL_VAR;
         end
         sws_pkg::ST_AVG_GO: begin
            cmd.div_start = 1'b1;
            cmd.div_sel   = sws_pkg::DSEL_AVG;
         end
         sws_pkg::ST_SQRT_GO: cmd.sqrt_start = 1'b1;
         sws_pkg::ST_DONE:    cmd.load_out = status.out_free;
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= sws_pkg::ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end
endmodule

[sv/sws_dp.sv]
// ----------------------------------------------------------------------------
// sws_dp
// Datapath: sample store, window pointers, scan accumulators, long-run
// statistics, shared divider and square root, result register.
// ----------------------------------------------------------------------------
module sws_dp #(
   parameter int WINDOW_MAX = 256
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  sws_pkg::ctrl_cmd_type                 cmd,
   output sws_pkg::ctrl_status_type              status,
   input  logic [sws_pkg::SAMPLE_BITS-1:0]       req_sample,
   input  logic [sws_pkg::CMD_W-1:0]             req_command,
   input  logic                                  cfg_wr,
   input  logic [sws_pkg::WSIZE_W-1:0]           cfg_wdata,
   output logic [$clog2(WINDOW_MAX+1)-1:0]       cfg_wsize,
   output logic                                  rsp_tvalid,
   input  logic                                  rsp_tready,
   output logic [sws_pkg::RSP_DATA_W-1:0]        rsp_tdata
);
   localparam int SB     = sws_pkg::SAMPLE_BITS;
   localparam int PTR_W  = (WINDOW_MAX > 2) ? $clog2(WINDOW_MAX) : 1;
   localparam int CNT_W  = $clog2(WINDOW_MAX + 1);
   localparam int IDX_W  = CNT_W + 1;
   localparam int SUM_W  = SB + CNT_W;
   localparam int SQ_W   = 2 * SB + CNT_W;
   localparam int NSQ_W  = CNT_W + SQ_W;
   localparam int SSQ_W  = 2 * SUM_W;
   localparam int DEN_W  = 2 * CNT_W;
   localparam int WCMP_W = (CNT_W > sws_pkg::WSIZE_W) ? CNT_W : sws_pkg::WSIZE_W;
   localparam int DW     = sws_pkg::DVD_W;
   localparam int MW     = sws_pkg::MEAN_W;
   localparam logic [CNT_W-1:0] WMAX_C   = CNT_W'(WINDOW_MAX);
   localparam logic [CNT_W-1:0] WS_RESET =
      CNT_W'((sws_pkg::WSIZE_RESET > WINDOW_MAX) ? WINDOW_MAX : sws_pkg::WSIZE_RESET);
   localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(WINDOW_MAX - 1);

   // ---- state ----
   logic signed [SB-1:0]    store_ff [WINDOW_MAX];
   logic signed [SB-1:0]    rd_data_ff;
   logic [PTR_W-1:0]        oldest_ff, oldest_in;
   logic [CNT_W-1:0]        fill_ff, fill_in;
   logic [CNT_W-1:0]        peak_ff, peak_in;
   logic [CNT_W-1:0]        wsize_ff, wsize_in;
   logic signed [DW-1:0]    macc_ff, macc_in;
   logic [sws_pkg::TOT_W-1:0] ptot_ff, ptot_in;
   logic                    push_ff;

   // scan
   logic [PTR_W-1:0]        p_ff, p_in;
   logic [CNT_W-1:0]        iss_ff, iss_in;
   logic                    rd_vld_ff, rd_vld_in;
   logic signed [SUM_W-1:0] sum_ff, sum_in;
   logic [SQ_W-1:0]         sq_ff, sq_in;
   logic signed [SB-1:0]    mn_ff, mn_in, mx_ff, mx_in;
   logic                    issue;
   logic signed [2*SB-1:0]  vsq;

   // products and results
   logic [NSQ_W-1:0]        nsq_ff;
   logic [SSQ_W-1:0]        ssq_ff;
   logic [DEN_W-1:0]        den_ff;
   logic [SUM_W-1:0]        sum_mag;
   logic [DW-1:0]           macc_mag;
   logic signed [MW-1:0]    mean_ff, avg_ff;
   logic [DW-1:0]           var_ff;
   logic [sws_pkg::ROOT_W-1:0] std_ff;
   logic                    neg_ff;
   sws_pkg::div_sel_type    sel_ff;

   // divider and root
   logic [DW-1:0]           dvd;
   logic [sws_pkg::DVS_W-1:0] dvs;
   logic [DW-1:0]           quo;
   logic [MW-1:0]           quo_s;
   logic                    div_done, sqrt_done;
   logic [sws_pkg::ROOT_W-1:0] root;

   // output
   logic                    ovld_ff;
   logic [sws_pkg::RSP_DATA_W-1:0] odata_ff;

   // ---- command apply ----
   logic                    is_push, mem_we;
   logic [IDX_W-1:0]        wsum, osum;
   logic [PTR_W-1:0]        wr_idx, o1;
   logic [CNT_W-1:0]        f1, drop;
   logic [WCMP_W-1:0]       wr_ext;

   always_comb begin
      is_push   = cmd.accept && (req_command == sws_pkg::CMD_PUSH);
      mem_we    = is_push;
      wsum      = IDX_W'(oldest_ff) + IDX_W'(fill_ff);
      wr_idx    = oldest_ff;
      o1        = oldest_ff;
      f1        = fill_ff;
      drop      = '0;
      osum      = '0;
      oldest_in = oldest_ff;
      fill_in   = fill_ff;
      peak_in   = peak_ff;
      macc_in   = macc_ff;
      ptot_in   = ptot_ff;
      if (fill_ff != WMAX_C) begin
         wr_idx = (wsum >= IDX_W'(WINDOW_MAX)) ? PTR_W'(wsum - IDX_W'(WINDOW_MAX))
                                               : PTR_W'(wsum);
         f1     = fill_ff + 1'b1;
      end else begin
         o1 = (oldest_ff == PTR_LAST) ? '0 : oldest_ff + 1'b1;
      end
      if (cmd.accept) begin
         case (req_command)
            sws_pkg::CMD_PUSH: begin
               if (f1 > wsize_ff) begin
                  // drop the oldest samples until the window fits
                  drop      = f1 - wsize_ff;
                  osum      = IDX_W'(o1) + IDX_W'(drop);
                  oldest_in = (osum >= IDX_W'(WINDOW_MAX))
                              ? PTR_W'(osum - IDX_W'(WINDOW_MAX)) : PTR_W'(osum);
                  fill_in   = wsize_ff;
               end else begin
                  oldest_in = o1;
                  fill_in   = f1;
               end
               if (fill_in > peak_ff) peak_in = fill_in;
            end
            sws_pkg::CMD_CLR_WIN: begin
               oldest_in = '0;
               fill_in   = '0;
            end
            sws_pkg::CMD_CLR_STATS: begin
               peak_in = '0;
               macc_in = '0;
               ptot_in = '0;
            end
            default: ;
         endcase
      end
      // long-run accumulation once the window mean is known
      if (cmd.acc && push_ff && (ptot_ff != '1)) begin
         macc_in = macc_ff + DW'(mean_ff);
         ptot_in = ptot_ff + 1'b1;
      end
   end

   // ---- configuration ----
   always_comb begin
      wr_ext   = WCMP_W'(cfg_wdata);
      wsize_in = wsize_ff;
      if (cfg_wr) begin
         if (wr_ext < WCMP_W'(2))               wsize_in = CNT_W'(2);
         else if (wr_ext > WCMP_W'(WINDOW_MAX)) wsize_in = WMAX_C;
         else                                   wsize_in = CNT_W'(wr_ext);
      end
   end

   // ---- scan ----
   always_comb begin
      issue     = cmd.scan_step && (iss_ff != fill_ff);
      p_in      = p_ff;
      iss_in    = iss_ff;
      rd_vld_in = issue;
      sum_in    = sum_ff;
      sq_in     = sq_ff;
      mn_in     = mn_ff;
      mx_in     = mx_ff;
      vsq       = rd_data_ff * rd_data_ff;
      if (cmd.accept) begin
         p_in   = oldest_in;
         iss_in = '0;
         sum_in = '0;
         sq_in  = '0;
         mn_in  = {1'b0, {(SB-1){1'b1}}};
         mx_in  = {1'b1, {(SB-1){1'b0}}};
      end else begin
         if (issue) begin
            p_in   = (p_ff == PTR_LAST) ? '0 : p_ff + 1'b1;
            iss_in = iss_ff + 1'b1;
         end
         if (rd_vld_ff) begin
            sum_in = sum_ff + SUM_W'(rd_data_ff);
            sq_in  = sq_ff + SQ_W'($unsigned(vsq));
            if (rd_data_ff < mn_ff) mn_in = rd_data_ff;
            if (rd_data_ff > mx_ff) mx_in = rd_data_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (mem_we) store_ff[wr_idx] <= $signed(req_sample);
      if (issue)  rd_data_ff <= store_ff[p_ff];
   end

   // ---- divider operands ----
   always_comb begin
      sum_mag  = sum_ff[SUM_W-1] ? SUM_W'(-sum_ff) : SUM_W'(sum_ff);
      macc_mag = macc_ff[DW-1] ? DW'(-macc_ff) : DW'(macc_ff);
      case (cmd.div_sel)
         sws_pkg::DSEL_VAR: begin
            dvd = (DW'(nsq_ff) - DW'(ssq_ff)) << sws_pkg::VAR_SHIFT;
            dvs = sws_pkg::DVS_W'(den_ff);
         end
         sws_pkg::DSEL_AVG: begin
            dvd = macc_mag;
            dvs = ptot_ff;
         end
         default: begin
            dvd = DW'({sum_mag, {sws_pkg::MEAN_FRAC{1'b0}}});
            dvs = sws_pkg::DVS_W'(fill_ff);
         end
      endcase
   end

   sws_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (cmd.div_start),
      .dividend (dvd),
      .divisor  (dvs),
      .quotient (quo),
      .done     (div_done)
   );

   sws_sqrt u_sqrt (
      .clock    (clock),
      .reset    (reset),
      .start    (cmd.sqrt_start),
      .radicand (var_ff),
      .root     (root),
      .done     (sqrt_done)
   );

   assign quo_s = neg_ff ? MW'(-quo[MW-1:0]) : quo[MW-1:0];

   // ---- registers ----
   always_ff @(posedge clock) begin
      if (reset) begin
         oldest_ff <= '0;
         fill_ff   <= '0;
         peak_ff   <= '0;
         macc_ff   <= '0;
         ptot_ff   <= '0;
         wsize_ff  <= WS_RESET;
         rd_vld_ff <= 1'b0;
         iss_ff    <= '0;
         ovld_ff   <= 1'b0;
      end else begin
         oldest_ff <= oldest_in;
         fill_ff   <= fill_in;
         peak_ff   <= peak_in;
         macc_ff   <= macc_in;
         ptot_ff   <= ptot_in;
         wsize_ff  <= wsize_in;
         rd_vld_ff <= rd_vld_in;
         iss_ff    <= iss_in;
         if (cmd.load_out)     ovld_ff <= 1'b1;
         else if (rsp_tready)  ovld_ff <= 1'b0;
      end
      p_ff   <= p_in;
      sum_ff <= sum_in;
      sq_ff  <= sq_in;
      mn_ff  <= mn_in;
      mx_ff  <= mx_in;
      if (cmd.accept) push_ff <= is_push;
      if (cmd.mul) begin
         nsq_ff <= fill_ff * sq_ff;
         ssq_ff <= sum_mag * sum_mag;
         den_ff <= fill_ff * (fill_ff - 1'b1);
      end
      if (cmd.div_start) begin
         sel_ff <= cmd.div_sel;
         neg_ff <= (cmd.div_sel == sws_pkg::DSEL_AVG) ? macc_ff[DW-1] : sum_ff[SUM_W-1];
      end
      if (div_done) begin
         case (sel_ff)
            sws_pkg::DSEL_VAR: var_ff  <= (fill_ff <= CNT_W'(1)) ? '0 : quo;
            sws_pkg::DSEL_AVG: avg_ff  <= (ptot_ff == '0) ? '0 : quo_s;
            default:           mean_ff <= (fill_ff == '0) ? '0 : quo_s;
         endcase
      end
      if (sqrt_done) std_ff <= root;
      if (cmd.load_out) begin
         odata_ff <= {
            {sws_pkg::RSP_PAD_W{1'b0}},
            ptot_ff,
            sws_pkg::CNT_OUT_W'(peak_ff),
            avg_ff,
            std_ff[sws_pkg::STD_W-1:0],
            var_ff[sws_pkg::MEAN_FRAC +: sws_pkg::VAR_OUT_W],
            (fill_ff == '0) ? SB'(0) : mx_ff,
            (fill_ff == '0) ? SB'(0) : mn_ff,
            mean_ff,
            sws_pkg::SUM_OUT_W'(sum_ff),
            sws_pkg::CNT_OUT_W'(fill_ff)
         };
      end
   end

   assign status.scan_done = (iss_ff == fill_ff) && !rd_vld_ff;
   assign status.div_done  = div_done;
   assign status.sqrt_done = sqrt_done;
   assign status.out_free  = !ovld_ff || rsp_tready;

   assign cfg_wsize  = wsize_ff;
   assign rsp_tvalid = ovld_ff;
   assign rsp_tdata  = odata_ff;
endmodule

[sv/sws_checker.sv]
// ----------------------------------------------------------------------------
// sws_checker
// Port-level assertions for the sliding window statistics block.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module sws_checker (
   input logic                                clock,
   input logic                                reset,
   input logic                                req_tvalid,
   input logic                                req_tready,
   input logic [sws_pkg::SAMPLE_BITS-1:0]     req_tdata,
   input logic [sws_pkg::CMD_W-1:0]           req_tuser,
   input logic                                rsp_tvalid,
   input logic                                rsp_tready,
   input logic [sws_pkg::RSP_DATA_W-1:0]      rsp_tdata,
   input logic                                csr_psel,
   input logic                                csr_penable,
   input logic                                csr_pwrite,
   input logic [sws_pkg::CSR_ADDR_W-1:0]      csr_paddr,
   input logic [sws_pkg::CSR_DATA_W-1:0]      csr_pwdata,
   input logic [sws_pkg::CSR_DATA_W-1:0]      csr_prdata,
   input logic                                csr_pready
);
   `SWS_ASSERT_RST(a_rst_no_rsp, clock, reset |=> !rsp_tvalid, "rsp valid after reset")
   `SWS_ASSERT_CLK(a_rsp_hold, clock, reset, (rsp_tvalid && !rsp_tready) |=> $stable(rsp_tdata), "rsp payload changed under stall")
   `SWS_ASSERT_CLK(a_one_at_time, clock, reset, (req_tvalid && req_tready) |=> !req_tready, "second command taken while busy")
   `SWS_ASSERT_CLK(a_min_le_max, clock, reset, rsp_tvalid |-> ($signed(rsp_tdata[72:57]) <= $signed(rsp_tdata[88:73])), "minimum above maximum")
endmodule

bind sliding_window_statistics sws_checker u_sws_checker (.*);
